// ----- hw/rtl/jbcd_pkg.sv -----
// shared types, constants and functions of the jpeg block coefficient decoder
`default_nettype none

package jbcd_pkg;

	localparam int unsigned JBCD_COMPONENTS = 4;
	localparam int unsigned BLOCK_COEFFS    = 64;
	localparam int unsigned POS_W           = $clog2(BLOCK_COEFFS);
	localparam int unsigned COEF_W          = 16;
	localparam int unsigned SYM_W           = 8;
	localparam int unsigned EXTRA_W         = 15;
	localparam logic [3:0]  RUN_ZRL         = 4'hf;
	localparam logic [3:0]  DC_SIZE_MAX     = 4'd15;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_EMPTY    = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_code_t;

	// what the datapath will do with the item on its inputs
	typedef enum logic [2:0] {
		ACT_STORE,
		ACT_STORE_EMIT,
		ACT_EMIT,
		ACT_ERR_EMPTY,
		ACT_ERR_OVERFLOW
	} action_t;

	typedef struct packed {
		logic             accept;
		logic             rd_en;
		logic             rd_last;
		logic [POS_W-1:0] rd_pos;
	} jbcd_cmd_t;

	// zig-zag index holding the coefficient of each natural position
	localparam logic [POS_W-1:0] NAT_TO_ZZ [BLOCK_COEFFS] = '{
		6'd0,  6'd1,  6'd5,  6'd6,  6'd14, 6'd15, 6'd27, 6'd28,
		6'd2,  6'd4,  6'd7,  6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
		6'd3,  6'd8,  6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
		6'd9,  6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
		6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
		6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
		6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
		6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63
	};

	// jpeg extend rule on the low size bits, 16 bit two's complement result
	function automatic logic [COEF_W-1:0] extend_bits(input logic [EXTRA_W-1:0] raw,
		input logic [3:0] size);
		logic [COEF_W-1:0] mask;
		logic [COEF_W-1:0] v;
		logic              neg;
		mask = (COEF_W'(1) << size) - COEF_W'(1);
		v    = {1'b0, raw} & mask;
		neg  = (v & (mask ^ (mask >> 1))) == '0;
		if (size == 4'd0) begin
			extend_bits = '0;
		end else if (neg) begin
			extend_bits = v - mask;
		end else begin
			extend_bits = v;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jbcd_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module jbcd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/jbcd_ctrl.sv -----
// controller: accept handshake and the natural order read sweep
`default_nettype none

module jbcd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire jbcd_pkg::action_t   action,
	output logic                     busy,
	output jbcd_pkg::jbcd_cmd_t      cmd
);

	import jbcd_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [POS_W-1:0] pos_q;
	logic             rd_s1;
	logic             accept;
	logic             ends_block;

	assign busy       = (state_q == ST_EMIT) || rd_s1;
	assign accept     = start && !busy;
	assign ends_block = (action == ACT_EMIT) || (action == ACT_STORE_EMIT);

	assign cmd.accept  = accept;
	assign cmd.rd_en   = (state_q == ST_EMIT);
	assign cmd.rd_pos  = pos_q;
	assign cmd.rd_last = (pos_q == POS_W'(BLOCK_COEFFS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && ends_block) begin
						state_q <= ST_EMIT;
						pos_q   <= '0;
					end
				end
				ST_EMIT: begin
					pos_q <= pos_q + POS_W'(1);
					if (cmd.rd_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/jbcd_datapath.sv -----
// datapath: predictors, coefficient store, valid bits and result register
`default_nettype none

module jbcd_datapath #(
	parameter int unsigned COMPONENTS = jbcd_pkg::JBCD_COMPONENTS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire jbcd_pkg::jbcd_cmd_t                 cmd,
	input  wire logic [1:0]                          component,
	input  wire logic [jbcd_pkg::SYM_W-1:0]          symbol,
	input  wire logic [jbcd_pkg::EXTRA_W-1:0]        extra_bits,
	output jbcd_pkg::action_t                        action,
	output logic                                     strobe,
	output logic signed [jbcd_pkg::COEF_W-1:0]       coefficient,
	output logic [jbcd_pkg::POS_W-1:0]               position,
	output logic                                     last_of_block,
	output logic [1:0]                               error_code
);

	import jbcd_pkg::*;

	localparam int unsigned CW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

	logic [COEF_W-1:0] pred_q [COMPONENTS];
	logic [POS_W-1:0]  seq_q;
	logic [BLOCK_COEFFS-1:0] valid_q;

	logic [2:0]        comp_rem;
	logic [CW-1:0]     comp_idx;
	logic [3:0]        run;
	logic [3:0]        size;
	logic [COEF_W-1:0] ext;
	logic [COEF_W-1:0] dc_sum;
	logic [POS_W:0]    idx;
	logic              dc_phase;
	logic              we;
	logic [POS_W-1:0]  waddr;
	logic [COEF_W-1:0] wdata;
	logic [POS_W-1:0]  raddr;
	logic [COEF_W-1:0] rdata;

	logic              en_s1;
	logic              hit_s1;
	logic              last_s1;
	logic [POS_W-1:0]  pos_s1;

	err_code_t         err_q;

	// component modulo the component count, by repeated compare and subtract
	always_comb begin
		comp_rem = {1'b0, component};
		for (int k = 0; k < 3; k++) begin
			if (comp_rem >= 3'(COMPONENTS)) begin
				comp_rem = comp_rem - 3'(COMPONENTS);
			end
		end
	end

	assign comp_idx = CW'(comp_rem);
	assign run      = symbol[7:4];
	assign size     = symbol[3:0];
	assign ext      = extend_bits(extra_bits, size);
	assign dc_sum   = pred_q[comp_idx] + ext;
	assign idx      = {1'b0, seq_q} + {3'b000, run};
	assign dc_phase = (seq_q == '0);

	always_comb begin
		priority if (dc_phase) begin
			action = (symbol > SYM_W'(DC_SIZE_MAX)) ? ACT_ERR_EMPTY : ACT_STORE;
		end else if (symbol == '0) begin
			action = ACT_EMIT;
		end else if ((size == 4'd0) && (run != RUN_ZRL)) begin
			action = ACT_ERR_EMPTY;
		end else if (idx[POS_W]) begin
			action = ACT_ERR_OVERFLOW;
		end else if (idx[POS_W-1:0] == POS_W'(BLOCK_COEFFS - 1)) begin
			action = ACT_STORE_EMIT;
		end else begin
			action = ACT_STORE;
		end
	end

	assign we    = cmd.accept && ((action == ACT_STORE) || (action == ACT_STORE_EMIT));
	assign waddr = dc_phase ? '0 : idx[POS_W-1:0];
	assign wdata = dc_phase ? dc_sum : ext;
	assign raddr = NAT_TO_ZZ[cmd.rd_pos];

	jbcd_ram #(
		.WIDTH(COEF_W),
		.DEPTH(BLOCK_COEFFS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// block state: predictors, fill position, entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMPONENTS; i++) begin
				pred_q[i] <= '0;
			end
			seq_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.accept) begin
				unique case (action)
					ACT_STORE: begin
						valid_q[waddr] <= 1'b1;
						if (dc_phase) begin
							pred_q[comp_idx] <= dc_sum;
							seq_q            <= POS_W'(1);
						end else begin
							seq_q <= idx[POS_W-1:0] + POS_W'(1);
						end
					end
					ACT_STORE_EMIT: begin
						valid_q[waddr] <= 1'b1;
						seq_q          <= '0;
					end
					ACT_EMIT: begin
						seq_q <= '0;
					end
					ACT_ERR_EMPTY, ACT_ERR_OVERFLOW: begin
						valid_q <= '0;
						seq_q   <= '0;
					end
					default: seq_q <= '0;
				endcase
			end
			// store is empty again once the sweep has read its last entry
			if (cmd.rd_en && cmd.rd_last) begin
				valid_q <= '0;
			end
		end
	end

	// read stage alongside the registered ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= valid_q[raddr];
		last_s1 <= cmd.rd_last;
		pos_s1  <= cmd.rd_pos;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= en_s1 || (cmd.accept &&
				((action == ACT_ERR_EMPTY) || (action == ACT_ERR_OVERFLOW)));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (action == ACT_ERR_EMPTY)) begin
			coefficient   <= '0;
			position      <= '0;
			last_of_block <= 1'b1;
			err_q         <= ERR_EMPTY;
		end else if (cmd.accept && (action == ACT_ERR_OVERFLOW)) begin
			coefficient   <= '0;
			position      <= '0;
			last_of_block <= 1'b1;
			err_q         <= ERR_OVERFLOW;
		end else if (en_s1) begin
			coefficient   <= hit_s1 ? $signed(rdata) : '0;
			position      <= pos_s1;
			last_of_block <= last_s1;
			err_q         <= ERR_NONE;
		end
	end

	assign error_code = err_q;

endmodule

`default_nettype wire

// ----- hw/rtl/jpeg_block_coefficient_decoder_core.sv -----
// top level of the jpeg baseline block coefficient decoder
`default_nettype none

// Rebuilds 8x8 blocks of quantized coefficients from Huffman-decoded baseline
// symbols. An item is taken at a rising edge with start high and busy low. An
// item that does not end a block leaves busy low, so such items can follow
// one per cycle. An error item puts its single result on the result ports in
// the next cycle. An item that ends a block (end of block, or the 64th
// coefficient) holds busy high for its read sweep: the 64 coefficients are
// read one a cycle in natural order through the single read port of the
// coefficient store, and busy stays high until the registered read of the last
// one is done, so the next item is taken only after that. Results come one per
// cycle, each shown for exactly one cycle with strobe high, and must be
// taken as they come: there is no way to hold them off. The store is emptied
// through per-entry valid bits, so there is no clearing pass after reset.
module jpeg_block_coefficient_decoder_core #(
	parameter int unsigned COMPONENTS = jbcd_pkg::JBCD_COMPONENTS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          component,
	input  wire logic [jbcd_pkg::SYM_W-1:0]          symbol,
	input  wire logic [jbcd_pkg::EXTRA_W-1:0]        extra_bits,
	output logic                                     strobe,
	output logic signed [jbcd_pkg::COEF_W-1:0]       coefficient,
	output logic [jbcd_pkg::POS_W-1:0]               position,
	output logic                                     last_of_block,
	output logic [1:0]                               error_code
);

	import jbcd_pkg::*;

	// action decided by the datapath for the item on the inputs
	action_t   action;
	// accept and read sweep commands from the controller
	jbcd_cmd_t cmd;

	jbcd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.busy  (busy),
		.cmd   (cmd)
	);

	jbcd_datapath #(
		.COMPONENTS(COMPONENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.component    (component),
		.symbol       (symbol),
		.extra_bits   (extra_bits),
		.action       (action),
		.strobe       (strobe),
		.coefficient  (coefficient),
		.position     (position),
		.last_of_block(last_of_block),
		.error_code   (error_code)
	);

	// a block-ending item locks out the next item
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && ((action == ACT_EMIT) || (action == ACT_STORE_EMIT)) |=> busy)
		else $error("block end did not raise busy");

	// every read of the sweep turns into a result, through the registered ram read and the result register
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> ##2 strobe)
		else $error("sweep read lost its result");

	// a good block ends exactly on the last raster position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (error_code == ERR_NONE) |->
		(last_of_block == (position == POS_W'(BLOCK_COEFFS - 1))))
		else $error("last flag out of place");

	// an error result is a lone, zeroed, block-closing result
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (error_code != ERR_NONE) |->
		last_of_block && (coefficient == '0) && (position == '0))
		else $error("malformed error result");

endmodule

`default_nettype wire
